[hw/rtl/sim_pkg.sv]
package sim_pkg;

  // Configuration register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_PERIOD    = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_STALE_THR = 2'd2,
    REG_NONE      = 2'd3
  } sim_reg_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } sim_state_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned ADDR_W = 4;

  localparam logic [DATA_W-1:0] ALL_ONES_32 = '1;
  localparam logic [SUM_W-1:0]  ALL_ONES_64 = '1;

  // Status returned by the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } sim_div_stat_t;

endpackage

[hw/rtl/sim_div.sv]
module sim_div
  import sim_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [DATA_W-1:0]   divisor,
  output sim_div_stat_t       stat,
  output logic [DATA_W-1:0]   quotient_sat
);

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic [DATA_W-1:0] rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              take;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    take    = (rem_sh >= {1'b0, dvs_r});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and the shared dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], take};
    end
  end

  // A quotient above 32 bits saturates.
  assign quotient_sat = (quo_r[SUM_W-1:DATA_W] != '0) ? ALL_ONES_32 : quo_r[DATA_W-1:0];
  assign stat         = '{busy: busy_r, done: done_r};

endmodule

[hw/rtl/sample_interval_monitor.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  sample_time, current_time, three flags
// out_      output     out_valid/out_stall  nine interval and age metrics
// APB       config     psel/penable/pready  period, tolerance, stale threshold
//
// Each item passes these steps from acceptance to its result being registered: update
// the statistics, run the bit-serial mean divider, take the quotient and load the
// output register. The first sample skips the divider.
// The next item is accepted in the cycle after the result is loaded at the earliest.
// Reset (rst_n low, synchronous) clears all statistics and configuration to zero.
// A stalled result holds the output register; the next item is still accepted meanwhile.
module sample_interval_monitor
  import sim_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [DATA_W-1:0]         in_sample_time,
  input  logic [DATA_W-1:0]         in_current_time,
  input  logic                      in_sample_valid,
  input  logic                      in_status_ok,
  input  logic                      in_driver_fault,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DATA_W-1:0]         out_last_interval,
  output logic [DATA_W-1:0]         out_min_interval,
  output logic [DATA_W-1:0]         out_max_interval,
  output logic [DATA_W-1:0]         out_mean_interval,
  output logic [DATA_W-1:0]         out_interval_total,
  output logic signed [DATA_W-1:0]  out_sched_delay,
  output logic [DATA_W-1:0]         out_missed_count,
  output logic [DATA_W-1:0]         out_valid_age,
  output logic                      out_stale,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  sim_state_t state_r, state_nxt;

  // Configuration registers.
  logic [DATA_W-1:0] period_r, tol_r, thr_r;
  sim_reg_t          reg_idx;
  logic              cfg_wr;

  // Captured input item.
  logic [DATA_W-1:0] smp_time_r, cur_time_r;
  logic              ok_r;

  // Statistics.
  logic              have_prev_r, have_valid_r, stale_r;
  logic [DATA_W-1:0] prev_time_r, cnt_r, min_r, max_r, latest_r, mean_r;
  logic [DATA_W-1:0] delay_r, missed_r, valid_time_r, age_r;
  logic [SUM_W-1:0]  sum_r;

  logic [DATA_W-1:0] cnt_nxt, min_nxt, max_nxt, missed_nxt, valid_time_nxt, age_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic              have_valid_nxt, stale_nxt;
  logic [DATA_W-1:0] iv, miss_lim;
  logic [SUM_W:0]    sum_add;

  // Output register.
  logic              out_valid_r;
  logic [DATA_W-1:0] o_last_r, o_min_r, o_max_r, o_mean_r, o_total_r, o_delay_r;
  logic [DATA_W-1:0] o_missed_r, o_age_r;
  logic              o_stale_r;

  // Sequencer outputs.
  logic              in_acc, div_start, load_out;

  sim_div_stat_t     div_stat;
  logic [DATA_W-1:0] div_q;

  // APB register file; writes are expected only while the block is idle.
  assign reg_idx = sim_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      tol_r    <= '0;
      thr_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PERIOD:    period_r <= pwdata;
        REG_TOLERANCE: tol_r    <= pwdata;
        REG_STALE_THR: thr_r    <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD:    prdata = period_r;
      REG_TOLERANCE: prdata = tol_r;
      REG_STALE_THR: prdata = thr_r;
      default:       prdata = '0;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CALC;
      ST_CALC: state_nxt = have_prev_r ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE: if (!(out_valid_r && out_stall)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_acc    = (state_r == ST_IDLE) && in_valid;
    div_start = (state_r == ST_CALC) && have_prev_r;
    load_out  = (state_r == ST_DONE) && !(out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_time_r <= in_sample_time;
      cur_time_r <= in_current_time;
      ok_r       <= in_sample_valid && in_status_ok && !in_driver_fault;
    end
  end

  // Interval statistics for the captured sample.
  always_comb begin
    iv       = smp_time_r - prev_time_r;
    miss_lim = period_r + tol_r;
    sum_add  = {1'b0, sum_r} + {{(SUM_W-DATA_W+1){1'b0}}, iv};
    sum_nxt  = sum_add[SUM_W] ? ALL_ONES_64 : sum_add[SUM_W-1:0];
    cnt_nxt  = (cnt_r == ALL_ONES_32) ? cnt_r : cnt_r + 1'b1;
    if (cnt_r == '0) begin
      min_nxt = iv;
      max_nxt = iv;
    end else begin
      min_nxt = (iv < min_r) ? iv : min_r;
      max_nxt = (iv > max_r) ? iv : max_r;
    end
    missed_nxt = ((iv > miss_lim) && (missed_r != ALL_ONES_32)) ? missed_r + 1'b1 : missed_r;
  end

  // Last valid sample, its age and the stale flag.
  always_comb begin
    valid_time_nxt = ok_r ? smp_time_r : valid_time_r;
    have_valid_nxt = ok_r || have_valid_r;
    age_nxt        = have_valid_nxt ? cur_time_r - valid_time_nxt : age_r;
    stale_nxt      = have_valid_nxt ? (age_nxt > thr_r) : stale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_time_r  <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      min_r        <= '0;
      max_r        <= '0;
      latest_r     <= '0;
      mean_r       <= '0;
      delay_r      <= '0;
      missed_r     <= '0;
      have_valid_r <= 1'b0;
      valid_time_r <= '0;
      age_r        <= '0;
      stale_r      <= 1'b0;
    end else begin
      if (state_r == ST_CALC) begin
        if (have_prev_r) begin
          latest_r <= iv;
          min_r    <= min_nxt;
          max_r    <= max_nxt;
          cnt_r    <= cnt_nxt;
          sum_r    <= sum_nxt;
          delay_r  <= iv - period_r;
          missed_r <= missed_nxt;
        end
        prev_time_r  <= smp_time_r;
        have_prev_r  <= 1'b1;
        valid_time_r <= valid_time_nxt;
        have_valid_r <= have_valid_nxt;
        age_r        <= age_nxt;
        stale_r      <= stale_nxt;
      end
      if (div_stat.done) mean_r <= div_q;
    end
  end

  // Mean divider, one quotient bit per cycle.
  sim_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (div_start),
    .dividend     (sum_nxt),
    .divisor      (cnt_nxt),
    .stat         (div_stat),
    .quotient_sat (div_q)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_last_r   <= latest_r;
      o_min_r    <= min_r;
      o_max_r    <= max_r;
      o_mean_r   <= mean_r;
      o_total_r  <= cnt_r;
      o_delay_r  <= delay_r;
      o_missed_r <= missed_r;
      o_age_r    <= age_r;
      o_stale_r  <= stale_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_last_interval  = o_last_r;
  assign out_min_interval   = o_min_r;
  assign out_max_interval   = o_max_r;
  assign out_mean_interval  = o_mean_r;
  assign out_interval_total = o_total_r;
  assign out_sched_delay    = o_delay_r;
  assign out_missed_count   = o_missed_r;
  assign out_valid_age      = o_age_r;
  assign out_stale          = o_stale_r;

endmodule

[hw/rtl/sim_checker.sv]
module sim_checker
  import sim_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [DATA_W-1:0]        out_last_interval,
  input logic [DATA_W-1:0]        out_min_interval,
  input logic [DATA_W-1:0]        out_max_interval,
  input logic [DATA_W-1:0]        out_mean_interval,
  input logic [DATA_W-1:0]        out_interval_total,
  input logic signed [DATA_W-1:0] out_sched_delay,
  input logic [DATA_W-1:0]        out_missed_count
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item was in progress");

  // A stalled result stays offered and its mean stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_interval))
    else $error("stalled result changed");

  // Minimum never exceeds maximum.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_interval <= out_max_interval)
    else $error("min_interval above max_interval");

  // Before the first interval all interval metrics are zero.
  a_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_interval_total == '0 |->
      out_last_interval == '0 && out_min_interval == '0 && out_max_interval == '0 &&
      out_mean_interval == '0 && out_sched_delay == '0 && out_missed_count == '0)
    else $error("interval metric nonzero before first interval");

endmodule

bind sample_interval_monitor sim_checker u_sim_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_last_interval  (out_last_interval),
  .out_min_interval   (out_min_interval),
  .out_max_interval   (out_max_interval),
  .out_mean_interval  (out_mean_interval),
  .out_interval_total (out_interval_total),
  .out_sched_delay    (out_sched_delay),
  .out_missed_count   (out_missed_count)
);
